FILE: rtl/command_packet_framer_crc8_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command packet framer
// Concurrent assertion shorthands that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef COMMAND_PACKET_FRAMER_CRC8_MACROS_SVH
`define COMMAND_PACKET_FRAMER_CRC8_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`ifndef SYNTH
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");
`else
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

// The consequent must hold in the same cycle as the antecedent.
`ifndef SYNTH
`define CPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");
`else
`define CPF_ASSERT_SAME(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/cpf_pkg.sv
// ---------------------------------------------------------------------------
// Command packet framer package
// Shared types, constants and the CRC-8 byte update.
// ---------------------------------------------------------------------------
package cpf_pkg;

   localparam int FRAME_LEN     = 10;
   localparam int PAYLOAD_BYTES = FRAME_LEN - 1;
   localparam int COUNT_W       = $clog2(FRAME_LEN);

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(FRAME_LEN - 1);

   typedef logic [COUNT_W-1:0] count_type;

   // Nine payload bytes, byte k in bits [8k+7:8k], and the running CRC.
   typedef struct packed {
      logic [PAYLOAD_BYTES-1:0][7:0] payload;
      logic [7:0]                    crc;
   } word_type;

   // One byte of CRC-8, polynomial x^8 + x^2 + x + 1, MSB first.
   function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/cpf_req_if.sv
// ---------------------------------------------------------------------------
// Command request channel
// Valid/ready channel carrying one command per request.
// ---------------------------------------------------------------------------
interface cpf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command_code;
   logic [31:0] yaw_bits;
   logic [31:0] pitch_bits;

   modport source (output valid, output command_code, output yaw_bits,
                   output pitch_bits, input ready);
   modport sink   (input valid, input command_code, input yaw_bits,
                   input pitch_bits, output ready);
endinterface

FILE: rtl/cpf_rsp_if.sv
// ---------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one frame byte per request.
// ---------------------------------------------------------------------------
interface cpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

FILE: rtl/cpf_crc_stage.sv
// ---------------------------------------------------------------------------
// CRC pipeline stage
// Folds one payload byte into the running CRC and registers the result.
// ---------------------------------------------------------------------------
module cpf_crc_stage #(
   parameter int BYTE_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cpf_pkg::word_type in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output cpf_pkg::word_type out_word
);
   import cpf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   word_type word_ff;
   word_type word_in;

   // The stage takes a new word whenever it is empty or its word moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      word_in     = in_word;
      word_in.crc = crc8_update(in_word.crc, in_word.payload[BYTE_INDEX]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

FILE: rtl/cpf_serializer.sv
// ---------------------------------------------------------------------------
// Frame serializer
// Holds one finished frame and sends it out one byte per request.
// ---------------------------------------------------------------------------
module cpf_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cpf_pkg::word_type in_word,
   cpf_rsp_if.source         rsp
);
   import cpf_pkg::*;

   logic                     busy_ff;
   logic                     busy_in;
   count_type                count_ff;
   count_type                count_in;
   logic [FRAME_LEN-1:0][7:0] bytes_ff;
   logic                     last;
   logic                     out_fire;
   logic                     load;

   assign last     = (count_ff == LAST_INDEX);
   assign out_fire = busy_ff && rsp.ready;
   // A new frame loads in the same cycle as the previous frame's CRC byte leaves.
   assign in_ready = !busy_ff || (rsp.ready && last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (load) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (out_fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= {in_word.crc, in_word.payload};
      end
   end

   assign rsp.valid      = busy_ff;
   assign rsp.frame_byte = bytes_ff[count_ff];
   assign rsp.frame_end  = last;
endmodule

FILE: rtl/command_packet_framer_crc8.sv
// ---------------------------------------------------------------------------
// Command packet framer with CRC-8
// Turns one command request into a ten-byte frame with a trailing CRC.
// ---------------------------------------------------------------------------
// Usage: a request on req_bus carries a command code and the raw bit patterns
// of yaw and pitch. The block answers with ten requests on rsp_bus: the
// command byte, yaw least significant byte first, pitch least significant byte
// first, and the CRC-8 (polynomial 0x07, initial value zero, no reflection,
// no final inversion). The CRC byte has frame_end set.
// The CRC is built in a nine-stage pipeline, one payload byte per stage,
// followed by a frame buffer that sends one byte per cycle while the
// receiver is ready. A request passes through the CRC stages and is then
// loaded into the frame buffer, which presents the first byte of the frame;
// the remaining bytes follow, ending with the CRC byte. Requests enter the
// pipeline every cycle while it has room, but the output channel moves at
// most one byte per cycle, so the sustained command rate is set by the serializer.
// A waiting next frame follows its predecessor's CRC byte without a gap.
// When the receiver stalls, the current byte is held and back pressure fills
// the pipeline stage by stage; nothing is dropped or repeated.
// Synchronous reset empties every stage and the frame buffer.
// ---------------------------------------------------------------------------
`include "command_packet_framer_crc8_macros.svh"

module command_packet_framer_crc8 (
   input  logic      clock,
   input  logic      reset,
   cpf_req_if.sink   req_bus,
   cpf_rsp_if.source rsp_bus
);
   import cpf_pkg::*;

   // Handshake and data between consecutive stages; index 0 is the request
   // side and the last index feeds the serializer.
   logic     stage_valid [PAYLOAD_BYTES+1];
   logic     stage_ready [PAYLOAD_BYTES+1];
   word_type stage_word  [PAYLOAD_BYTES+1];

   // The payload is laid out so that payload byte k is the k-th frame byte.
   assign stage_valid[0]      = req_bus.valid;
   assign req_bus.ready       = stage_ready[0];
   assign stage_word[0].payload = {req_bus.pitch_bits, req_bus.yaw_bits,
                                   req_bus.command_code};
   assign stage_word[0].crc   = CRC_INIT;

   for (genvar g = 0; g < PAYLOAD_BYTES; g++) begin : g_crc
      cpf_crc_stage #(
         .BYTE_INDEX(g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (stage_valid[g]),
         .in_ready (stage_ready[g]),
         .in_word  (stage_word[g]),
         .out_valid(stage_valid[g+1]),
         .out_ready(stage_ready[g+1]),
         .out_word (stage_word[g+1])
      );
   end

   // The serializer holds a whole frame while the pipeline keeps its next ones.
   cpf_serializer u_serializer (
      .clock   (clock),
      .reset   (reset),
      .in_valid(stage_valid[PAYLOAD_BYTES]),
      .in_ready(stage_ready[PAYLOAD_BYTES]),
      .in_word (stage_word[PAYLOAD_BYTES]),
      .rsp     (rsp_bus)
   );

   // Within a frame, every byte is followed directly by the next one.
   `CPF_ASSERT_NEXT(a_frame_contiguous, clock, reset,
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.frame_end, rsp_bus.valid)
   // A finished word waiting on a busy serializer is held unchanged.
   `CPF_ASSERT_NEXT(a_last_stage_holds, clock, reset,
      stage_valid[PAYLOAD_BYTES] && !stage_ready[PAYLOAD_BYTES],
      stage_valid[PAYLOAD_BYTES] && $stable(stage_word[PAYLOAD_BYTES]))
   // A waiting frame starts right after the previous CRC byte leaves.
   `CPF_ASSERT_NEXT(a_back_to_back, clock, reset,
      rsp_bus.valid && rsp_bus.ready && rsp_bus.frame_end
         && stage_valid[PAYLOAD_BYTES],
      rsp_bus.valid && !rsp_bus.frame_end)
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Command packet framer testbench
// Sends command requests and checks every byte of every ten-byte frame and
// its CRC-8 against a predictor, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module testbench;
   import cpf_pkg::*;

   // Half of the 2 ns clock period.
   localparam real HALF_PERIOD  = 1.0;
   localparam int  RESET_CYCLES = 10;
   // The run is declared hung after this many cycles without any accepted request.
   localparam int  STALL_LIMIT  = 2000;
   // Cycles watched after the last expected byte, so that stray bytes show up.
   localparam int  DRAIN_CYCLES = 40;
   localparam int  RANDOM_IDLING_ITEMS = 90;
   localparam int  RANDOM_STEADY_ITEMS = 25;

   // Single-precision bit patterns that the framer has to pass untouched.
   localparam logic [31:0] FLT_POS_ZERO    = 32'h0000_0000;
   localparam logic [31:0] FLT_NEG_ZERO    = 32'h8000_0000;
   localparam logic [31:0] FLT_POS_INF     = 32'h7F80_0000;
   localparam logic [31:0] FLT_NEG_INF     = 32'hFF80_0000;
   localparam logic [31:0] FLT_QUIET_NAN   = 32'h7FC0_0000;
   localparam logic [31:0] FLT_SIGNAL_NAN  = 32'h7F80_0001;
   localparam logic [31:0] FLT_MIN_DENORM  = 32'h0000_0001;
   localparam logic [31:0] FLT_MAX_DENORM  = 32'h007F_FFFF;
   localparam logic [31:0] FLT_NEG_DENORM  = 32'h8000_0001;
   localparam logic [31:0] FLT_MIN_NORMAL  = 32'h0080_0000;
   localparam logic [31:0] FLT_MAX_FINITE  = 32'h7F7F_FFFF;
   localparam logic [31:0] FLT_POS_ONE     = 32'h3F80_0000;
   localparam logic [31:0] FLT_NEG_ONE     = 32'hBF80_0000;
   localparam logic [31:0] FLT_ALL_ONES    = 32'hFFFF_FFFF;

   // One expected frame byte.
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_beat_type;

   // One row of the directed table. Where crc_known is set, the CRC byte is
   // taken from the row instead of the predictor.
   typedef struct packed {
      logic [7:0]  code;
      logic [31:0] yaw;
      logic [31:0] pitch;
      logic        crc_known;
      logic [7:0]  crc;
   } command_row_type;

   logic clock;
   logic reset;

   cpf_req_if req_bus ();
   cpf_rsp_if rsp_bus ();

   command_packet_framer_crc8 u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Frame bytes predicted for every accepted command, oldest first.
   frame_beat_type expected_bytes[$];

   int  error_count    = 0;
   int  bytes_checked  = 0;
   int  commands_sent  = 0;
   int  idle_cycles    = 0;
   // While idling_on is clear, neither side inserts gaps or stalls.
   bit  idling_on      = 1'b1;

   // The directed table. The all-zero frame must carry a zero CRC, and the
   // frame that spells the ASCII string 123456789 must carry the well-known
   // check value of this CRC. Every other row is left to the predictor.
   command_row_type directed_rows [16] = '{
      '{8'h00, FLT_POS_ZERO,   FLT_POS_ZERO,   1'b1, 8'h00},
      '{8'h31, 32'h3534_3332,  32'h3938_3736,  1'b1, 8'hF4},
      '{8'hFF, FLT_ALL_ONES,   FLT_ALL_ONES,   1'b0, 8'h00},
      '{8'hFF, FLT_POS_ZERO,   FLT_POS_ZERO,   1'b0, 8'h00},
      '{8'h00, FLT_ALL_ONES,   FLT_POS_ZERO,   1'b0, 8'h00},
      '{8'h00, FLT_POS_ZERO,   FLT_ALL_ONES,   1'b0, 8'h00},
      '{8'h10, FLT_POS_INF,    FLT_NEG_INF,    1'b0, 8'h00},
      '{8'h11, FLT_QUIET_NAN,  FLT_SIGNAL_NAN, 1'b0, 8'h00},
      '{8'h12, FLT_MIN_DENORM, FLT_MAX_DENORM, 1'b0, 8'h00},
      '{8'h13, FLT_NEG_ZERO,   FLT_NEG_DENORM, 1'b0, 8'h00},
      '{8'h14, FLT_POS_ONE,    FLT_NEG_ONE,    1'b0, 8'h00},
      '{8'h15, FLT_MAX_FINITE, FLT_MIN_NORMAL, 1'b0, 8'h00},
      '{8'hAA, 32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 8'h00},
      '{8'h55, 32'h5555_5555,  32'hAAAA_AAAA,  1'b0, 8'h00},
      '{8'h80, 32'h8000_0000,  32'h0000_0001,  1'b0, 8'h00},
      '{8'h01, 32'h0000_0001,  32'h8000_0000,  1'b0, 8'h00}
   };

   always #(HALF_PERIOD) clock = ~clock;

   // Every input of the block has a known value from time zero on.
   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.command_code = 8'h00;
      req_bus.yaw_bits     = 32'h0;
      req_bus.pitch_bits   = 32'h0;
      rsp_bus.ready        = 1'b0;
   end

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("testbench: mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // CRC-8 over the nine payload bytes, worked out one bit at a time:
   // the top bit of the register is compared with the incoming data bit, and
   // when they differ the shifted register takes the polynomial.
   function automatic logic [7:0] frame_crc(input logic [7:0] payload [9]);
      logic [7:0] remainder;
      logic       feedback;
      remainder = CRC_INIT;
      for (int b = 0; b < 9; b++) begin
         for (int k = 7; k >= 0; k--) begin
            feedback  = remainder[7] ^ payload[b][k];
            remainder = {remainder[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
         end
      end
      return remainder;
   endfunction

   // Random gap length for either side: most often none, otherwise a burst.
   function automatic int pick_gap();
      if (!idling_on || $urandom_range(0, 2) != 0) begin
         return 0;
      end
      return $urandom_range(1, 17);
   endfunction

   // Random field value, biased toward the bit patterns that matter for floats
   // and toward single set or cleared bits, with plain random words mixed in.
   function automatic logic [31:0] random_pattern();
      logic [31:0] specials [8];
      logic [31:0] one_hot;
      specials = '{FLT_POS_ZERO, FLT_NEG_ZERO, FLT_POS_INF, FLT_NEG_INF,
                   FLT_QUIET_NAN, FLT_ALL_ONES, FLT_MIN_DENORM, FLT_MAX_DENORM};
      one_hot = 32'h1 << $urandom_range(0, 31);
      case ($urandom_range(0, 5))
         0: begin
            return specials[$urandom_range(0, 7)];
         end
         1: begin
            return one_hot;
         end
         2: begin
            return ~one_hot;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Presents one command request and holds it until the framer takes it.
   // The handshake is sampled at the falling edge, so acceptance at the
   // following rising edge is known without depending on event order. At the
   // accepting edge the ten expected bytes are queued; the first of them
   // cannot appear before the next falling edge. The valid line is lowered
   // only when a gap follows, so that it never gets two updates in one step.
   task automatic issue_command(input logic [7:0] code, input logic [31:0] yaw,
                                input logic [31:0] pitch, input logic crc_known,
                                input logic [7:0] crc_typed, input int gap);
      logic [7:0]     payload [9];
      frame_beat_type beat;
      bit             taken;
      req_bus.valid        <= 1'b1;
      req_bus.command_code <= code;
      req_bus.yaw_bits     <= yaw;
      req_bus.pitch_bits   <= pitch;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);

      payload[0] = code;
      for (int i = 0; i < 4; i++) begin
         payload[1 + i] = yaw[8 * i +: 8];
         payload[5 + i] = pitch[8 * i +: 8];
      end
      for (int i = 0; i < 9; i++) begin
         beat.value = payload[i];
         beat.last  = 1'b0;
         expected_bytes = {expected_bytes, beat};
      end
      beat.value = crc_known ? crc_typed : frame_crc(payload);
      beat.last  = 1'b1;
      expected_bytes = {expected_bytes, beat};
      commands_sent++;

      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Compares one accepted frame byte with the oldest expectation.
   task automatic check_frame_byte(input logic [7:0] got_byte, input logic got_end);
      frame_beat_type want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("frame byte %02h arrived with nothing expected",
                                   got_byte));
      end else begin
         want = expected_bytes.pop_front();
         if (got_byte !== want.value) begin
            report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                      got_byte, want.value));
         end
         if (got_end !== want.last) begin
            report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                      got_end, want.last, want.value));
         end
      end
   endtask

   // Receiver: ready is held high except for random stall bursts. A stall
   // may start on any cycle, so it can land on any byte position of a frame.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && idling_on && $urandom_range(0, 6) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Frame byte monitor and watchdog, both sampled at the falling edge when
   // every signal has settled. A cycle in which neither a command request nor
   // a frame byte request is accepted counts toward the hang limit.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_frame_byte(rsp_bus.frame_byte, rsp_bus.frame_end);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: hang, no request accepted for %0d cycles", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // Stimulus: reset, the directed table, a pause until the framer has sent
   // everything, random commands with idling, then a steady stretch without
   // any gaps or stalls so that frames follow each other back to back.
   initial begin
      @(posedge clock);
      repeat (RESET_CYCLES - 1) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < 16; r++) begin
         issue_command(directed_rows[r].code, directed_rows[r].yaw,
                       directed_rows[r].pitch, directed_rows[r].crc_known,
                       directed_rows[r].crc, pick_gap());
      end

      // Hold the sender off until every byte of the directed frames is out.
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_IDLING_ITEMS; n++) begin
         issue_command(8'($urandom_range(0, 255)), random_pattern(), random_pattern(),
                       1'b0, 8'h00, pick_gap());
      end

      idling_on = 1'b0;
      for (int n = 0; n < RANDOM_STEADY_ITEMS; n++) begin
         issue_command(8'($urandom_range(0, 255)), random_pattern(), random_pattern(),
                       1'b0, 8'h00, 0);
      end
      req_bus.valid <= 1'b0;

      // The watchdog ends the run if the framer never delivers the rest.
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("testbench: %0d commands framed, %0d frame bytes checked, %0d mismatches",
               commands_sent, bytes_checked, error_count);
      $display("testbench: covered zero and all-one frames, float specials, gaps and stalls");
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cpf_pkg.sv
rtl/cpf_req_if.sv
rtl/cpf_rsp_if.sv
rtl/cpf_crc_stage.sv
rtl/cpf_serializer.sv
rtl/command_packet_framer_crc8.sv
sim/testbench.sv
